// ===== rtl/tlrq_pkg.sv =====
package tlrq_pkg;

    localparam int NUM_TASKS_DEF = 16;
    localparam int TASK_W        = 4;
    localparam int CODE_W        = 2;
    localparam int IN_DATA_W     = 8;
    localparam int OUT_DATA_W    = 8;

    // dispatch result codes
    localparam logic [CODE_W-1:0] CODE_IDLE = 2'd0;
    localparam logic [CODE_W-1:0] CODE_LAST = 2'd1;
    localparam logic [CODE_W-1:0] CODE_MORE = 2'd2;

    // item kind carried in s_tuser
    localparam logic MODE_READY    = 1'b0;
    localparam logic MODE_DISPATCH = 1'b1;

    typedef struct packed {
        logic push;   // make the accepted task ready
        logic pop;    // dispatch the next ready task into the output register
    } tlrq_cmd_t;

    typedef struct packed {
        logic out_busy;   // output register holds an item that is not taken this cycle
    } tlrq_status_t;

endpackage

// ===== rtl/tlrq_ctrl.sv =====
module tlrq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tuser,
    output logic                  s_tready,
    input  tlrq_pkg::tlrq_status_t status,
    output tlrq_pkg::tlrq_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_POP  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd.push   = 1'b0;
        cmd.pop    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == tlrq_pkg::MODE_DISPATCH)
                        state_next = ST_POP;
                    else
                        cmd.push = 1'b1;
                end
            end
            ST_POP:
            begin
                // hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd.pop    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/tlrq_datapath.sv =====
module tlrq_datapath #(
    parameter int NUM_TASKS = tlrq_pkg::NUM_TASKS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tlrq_pkg::tlrq_cmd_t               cmd,
    output tlrq_pkg::tlrq_status_t            status,
    input  logic [tlrq_pkg::TASK_W-1:0]       task_id,
    input  logic                              urgent,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tlrq_pkg::CODE_W-1:0]       dispatch_code,
    output logic [tlrq_pkg::TASK_W-1:0]       chosen_task
);

    localparam int PTR_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W = $clog2(NUM_TASKS + 1);
    localparam int TW    = tlrq_pkg::TASK_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(NUM_TASKS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_TASKS);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [TW-1:0]        urg_mem [NUM_TASKS];
    logic [TW-1:0]        nrm_mem [NUM_TASKS];
    logic [TW-1:0]        urg_rd_reg;
    logic [TW-1:0]        nrm_rd_reg;
    logic [NUM_TASKS-1:0] mark_reg;
    logic [NUM_TASKS-1:0] mark_next;
    logic [PTR_W-1:0]     urg_head_reg, urg_tail_reg, nrm_head_reg, nrm_tail_reg;
    logic [CNT_W-1:0]     urg_cnt_reg, nrm_cnt_reg;
    logic                 out_valid_reg;
    logic [tlrq_pkg::CODE_W-1:0] code_reg;
    logic [TW-1:0]        task_reg;

    logic [PTR_W-1:0] tid_idx;
    logic             tid_ok;
    logic             push_ok;
    logic             push_urg, push_nrm;
    logic             urg_avail, nrm_avail, any_avail;
    logic             pop_urg, pop_nrm;
    logic [TW-1:0]    pop_task;
    logic             more_left;

    assign tid_idx   = PTR_W'(task_id);
    assign tid_ok    = (32'(task_id) < NUM_TASKS);
    assign push_ok   = cmd.push && tid_ok && !mark_reg[tid_idx];
    assign push_urg  = push_ok && urgent && (urg_cnt_reg != CNT_FULL);
    assign push_nrm  = push_ok && !urgent && (nrm_cnt_reg != CNT_FULL);

    assign urg_avail = (urg_cnt_reg != '0);
    assign nrm_avail = (nrm_cnt_reg != '0);
    assign any_avail = urg_avail || nrm_avail;
    assign pop_urg   = cmd.pop && urg_avail;
    assign pop_nrm   = cmd.pop && !urg_avail && nrm_avail;
    assign pop_task  = urg_avail ? urg_rd_reg : nrm_rd_reg;
    assign more_left = urg_avail ? ((urg_cnt_reg != CNT_ONE) || nrm_avail)
                                 : (nrm_cnt_reg != CNT_ONE);

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign dispatch_code   = code_reg;
    assign chosen_task     = task_reg;

    // queue storage, read at the head every cycle
    always_ff @(posedge clk)
    begin
        if (push_urg)
            urg_mem[urg_tail_reg] <= task_id;
        if (push_nrm)
            nrm_mem[nrm_tail_reg] <= task_id;
        urg_rd_reg <= urg_mem[urg_head_reg];
        nrm_rd_reg <= nrm_mem[nrm_head_reg];
    end

    always_comb
    begin
        mark_next = mark_reg;
        if (push_urg || push_nrm)
            mark_next[tid_idx] = 1'b1;
        if (pop_urg || pop_nrm)
            mark_next[PTR_W'(pop_task)] = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg      <= '0;
            urg_head_reg  <= '0;
            urg_tail_reg  <= '0;
            urg_cnt_reg   <= '0;
            nrm_head_reg  <= '0;
            nrm_tail_reg  <= '0;
            nrm_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mark_reg <= mark_next;
            if (push_urg)
            begin
                urg_tail_reg <= (urg_tail_reg == PTR_LAST) ? '0 : urg_tail_reg + 1'b1;
                urg_cnt_reg  <= urg_cnt_reg + 1'b1;
            end
            if (push_nrm)
            begin
                nrm_tail_reg <= (nrm_tail_reg == PTR_LAST) ? '0 : nrm_tail_reg + 1'b1;
                nrm_cnt_reg  <= nrm_cnt_reg + 1'b1;
            end
            if (pop_urg)
            begin
                urg_head_reg <= (urg_head_reg == PTR_LAST) ? '0 : urg_head_reg + 1'b1;
                urg_cnt_reg  <= urg_cnt_reg - 1'b1;
            end
            if (pop_nrm)
            begin
                nrm_head_reg <= (nrm_head_reg == PTR_LAST) ? '0 : nrm_head_reg + 1'b1;
                nrm_cnt_reg  <= nrm_cnt_reg - 1'b1;
            end
            if (cmd.pop)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            if (!any_avail)
            begin
                code_reg <= tlrq_pkg::CODE_IDLE;
                task_reg <= '0;
            end
            else
            begin
                code_reg <= more_left ? tlrq_pkg::CODE_MORE : tlrq_pkg::CODE_LAST;
                task_reg <= pop_task;
            end
        end
    end

endmodule

// ===== rtl/two_level_ready_queue_scheduler.sv =====
// Strict-priority ready queue scheduler with two FIFO queues of task numbers,
// urgent and normal, and one ready mark per task. Each input item carries its
// kind in s_tuser: a make-ready item appends task_id to the queue that urgent
// selects, unless the task is already marked ready or is not below NUM_TASKS,
// and produces no result. A dispatch item pops the urgent head, or the normal
// head when the urgent queue is empty, clears the task's mark and returns one
// result: dispatch_code 0 when nothing is ready (chosen_task 0), 1 when the
// queues are now empty, 2 when more work is pending. A make-ready item is done
// in its accept cycle; a dispatch item goes to ST_POP, past the registered read
// port of the queue memories, and waits while the output register holds an
// untaken result. One item is in work at a time; a finished result sits in the
// output register and does not block the next make-ready item.
module two_level_ready_queue_scheduler #(
    parameter int NUM_TASKS = tlrq_pkg::NUM_TASKS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tlrq_pkg::IN_DATA_W-1:0]     s_tdata,   // [3:0] task_id, [4] urgent
    input  logic                               s_tuser,   // [0] mode
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tlrq_pkg::OUT_DATA_W-1:0]    m_tdata    // [1:0] dispatch_code, [5:2] chosen_task
);

    tlrq_pkg::tlrq_cmd_t             cmd;
    tlrq_pkg::tlrq_status_t          status;
    logic [tlrq_pkg::CODE_W-1:0]     dispatch_code;
    logic [tlrq_pkg::TASK_W-1:0]     chosen_task;

    // sequence each item: push on acceptance, dispatch after the queue read
    tlrq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // queues, ready marks and the output register
    tlrq_datapath #(
        .NUM_TASKS (NUM_TASKS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .task_id       (s_tdata[3:0]),
        .urgent        (s_tdata[4]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .dispatch_code (dispatch_code),
        .chosen_task   (chosen_task)
    );

    // pack the result, zero fill to a whole byte
    assign m_tdata = {2'b00, chosen_task, dispatch_code};

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

typedef struct packed {
    logic [tlrq_pkg::CODE_W-1:0] code;
    logic [tlrq_pkg::TASK_W-1:0] chosen;
} dispatch_t;

// Tracks the two ready queues and the ready marks, and holds the dispatch
// results still owed by the block, oldest first.
class ready_queue_model;
    bit                          ready_mark [tlrq_pkg::NUM_TASKS_DEF];
    logic [tlrq_pkg::TASK_W-1:0] urgent_line [$];
    logic [tlrq_pkg::TASK_W-1:0] normal_line [$];
    dispatch_t                   owed_results [$];
    int                          errors;

    function new();
        foreach (ready_mark[i]) ready_mark[i] = 0;
        errors = 0;
    endfunction

    function int pending();
        return owed_results.size();
    endfunction

    // Apply one accepted item; return 1 when it changed state or owes a result.
    function bit take_item(logic mode, logic [tlrq_pkg::TASK_W-1:0] tid, logic urg);
        dispatch_t                   res;
        logic [tlrq_pkg::TASK_W-1:0] pick;
        if (mode == tlrq_pkg::MODE_READY)
        begin
            if (ready_mark[tid])
                return 0;
            if (urg)
            begin
                if (urgent_line.size() >= tlrq_pkg::NUM_TASKS_DEF)
                    return 0;
                urgent_line.push_back(tid);
            end
            else
            begin
                if (normal_line.size() >= tlrq_pkg::NUM_TASKS_DEF)
                    return 0;
                normal_line.push_back(tid);
            end
            ready_mark[tid] = 1;
            return 1;
        end
        if (urgent_line.size() != 0)
            pick = urgent_line.pop_front();
        else if (normal_line.size() != 0)
            pick = normal_line.pop_front();
        else
        begin
            res.code   = tlrq_pkg::CODE_IDLE;
            res.chosen = '0;
            owed_results.push_back(res);
            return 1;
        end
        ready_mark[pick] = 0;
        res.code   = (urgent_line.size() != 0 || normal_line.size() != 0)
                     ? tlrq_pkg::CODE_MORE : tlrq_pkg::CODE_LAST;
        res.chosen = pick;
        owed_results.push_back(res);
        return 1;
    endfunction

    function void check_dispatch(logic [tlrq_pkg::OUT_DATA_W-1:0] data);
        dispatch_t want;
        if (owed_results.size() == 0)
        begin
            $error("result with nothing owed: m_tdata %h", data);
            errors++;
            return;
        end
        want = owed_results.pop_front();
        if (data[1:0] !== want.code)
        begin
            $error("dispatch_code: expected %0d, got %0d", want.code, data[1:0]);
            errors++;
        end
        if (data[5:2] !== want.chosen)
        begin
            $error("chosen_task: expected %0d, got %0d", want.chosen, data[5:2]);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam int ITEM_GOAL   = 850;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_WAIT    = 12;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [tlrq_pkg::IN_DATA_W-1:0]  s_tdata;    // [3:0] task_id, [4] urgent
    logic                            s_tuser;    // [0] mode
    logic                            m_tvalid;
    logic                            m_tready;
    logic [tlrq_pkg::OUT_DATA_W-1:0] m_tdata;    // [1:0] dispatch_code, [5:2] chosen_task

    ready_queue_model sched = new();

    int  counted_items;   // items accepted by the block
    int  cycles;
    bit  tx_calm;         // sender skips its gaps while set
    bit  rx_calm;         // receiver holds m_tready high while set

    two_level_ready_queue_scheduler DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Bound the run; a hang ends here as a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Check every result the block hands over.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sched.check_dispatch(m_tdata);
    end

    // Receiver: stall a random number of cycles before taking each result.
    initial
    begin
        int w;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            w = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (w > 0)
            begin
                m_tready = 1'b0;
                repeat (w) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Drive one item after a random gap, hold it until accepted, then log it.
    // Keep s_tvalid high across back-to-back items so it never drops and
    // rises in the same step.
    task automatic send_item(input logic mode, input logic [tlrq_pkg::TASK_W-1:0] tid,
                             input logic urg);
        int gap;
        @(negedge clk);
        gap = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = {3'b000, urg, tid};
        do @(posedge clk); while (!s_tready);
        void'(sched.take_item(mode, tid, urg));
        counted_items++;
    endtask

    task automatic dispatch_one();
        send_item(tlrq_pkg::MODE_DISPATCH, tlrq_pkg::TASK_W'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)));
    endtask

    // Hold off the sender until every owed result has come back.
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sched.pending() != 0) @(negedge clk);
    endtask

    // Make every task ready in shuffled order, then dispatch past empty.
    task automatic fill_and_empty(input int urg_style);
        int order [tlrq_pkg::NUM_TASKS_DEF];
        int j;
        int t;
        foreach (order[i]) order[i] = i;
        for (int i = tlrq_pkg::NUM_TASKS_DEF - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        foreach (order[i])
            send_item(tlrq_pkg::MODE_READY, tlrq_pkg::TASK_W'(order[i]),
                      urg_style == 0 ? 1'($urandom_range(0, 1)) : (urg_style == 1));
        repeat (tlrq_pkg::NUM_TASKS_DEF + 1) dispatch_one();
    endtask

    initial
    begin
        int kind;
        int n;
        int p_ready;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = tlrq_pkg::MODE_READY;
        rst_n    = 1'b0;
        tx_calm  = 1'b0;
        rx_calm  = 1'b0;
        counted_items = 0;
        cycles   = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty dispatch, both queues, already-ready tasks,
        // urgent-first order, re-ready after dispatch, drain to empty.
        send_item(tlrq_pkg::MODE_DISPATCH, 4'd15, 1'b1);
        send_item(tlrq_pkg::MODE_READY,    4'd0,  1'b1);
        send_item(tlrq_pkg::MODE_READY,    4'd15, 1'b0);
        send_item(tlrq_pkg::MODE_READY,    4'd15, 1'b1);
        send_item(tlrq_pkg::MODE_READY,    4'd0,  1'b0);
        send_item(tlrq_pkg::MODE_READY,    4'd5,  1'b0);
        send_item(tlrq_pkg::MODE_READY,    4'd10, 1'b1);
        send_item(tlrq_pkg::MODE_DISPATCH, 4'd0,  1'b0);
        send_item(tlrq_pkg::MODE_DISPATCH, 4'd10, 1'b1);
        send_item(tlrq_pkg::MODE_READY,    4'd0,  1'b0);
        send_item(tlrq_pkg::MODE_DISPATCH, 4'd3,  1'b0);
        send_item(tlrq_pkg::MODE_DISPATCH, 4'd12, 1'b1);
        send_item(tlrq_pkg::MODE_DISPATCH, 4'd7,  1'b0);
        send_item(tlrq_pkg::MODE_DISPATCH, 4'd8,  1'b1);
        drain();

        // Random: mostly mixed traffic and full fill/empty sweeps, some noise.
        while (counted_items < ITEM_GOAL)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            kind    = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                n       = $urandom_range(10, 40);
                p_ready = $urandom_range(20, 80);
                repeat (n)
                begin
                    if ($urandom_range(1, 100) <= p_ready)
                        send_item(tlrq_pkg::MODE_READY,
                                  tlrq_pkg::TASK_W'($urandom_range(0, 15)),
                                  1'($urandom_range(0, 1)));
                    else
                        dispatch_one();
                end
            end
            else if (kind <= 7)
            begin
                fill_and_empty($urandom_range(0, 2));
            end
            else if (kind == 8)
            begin
                // Hammer a few tasks so most make-ready items hit a set mark.
                repeat ($urandom_range(8, 20))
                begin
                    if ($urandom_range(0, 3) == 0)
                        dispatch_one();
                    else
                        send_item(tlrq_pkg::MODE_READY,
                                  tlrq_pkg::TASK_W'($urandom_range(0, 2)),
                                  1'($urandom_range(0, 1)));
                end
            end
            else
            begin
                drain();
            end
        end

        drain();
        repeat (20) @(negedge clk);
        if (sched.errors == 0 && sched.pending() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
